// ===== hw/rtl/md5_message_digest_defines.svh =====
// ----------------------------------------------------------------------------
// MD5 message digest: assertion macros
// Shared check macros for the MD5 digest block, clocked on clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define MD5_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MD5_ASSERT_IMPLY(lbl, ante, cons, msg)
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 package
// Types, round constants and small round-schedule functions for MD5.
// ----------------------------------------------------------------------------
package md5_pkg;

    // Four chaining words, index 0 is word A.
    typedef logic [3:0][31:0] md5_chain_t;

    typedef struct packed {
        logic start;   // load working words from the chain, run 64 rounds
        logic reload;  // restore the chain to its initial value
    } md5_core_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;    // final accumulate happens at this edge
    } md5_core_status_t;

    localparam md5_chain_t CHAIN_INIT = {
        32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] PAD_LIMIT = 6'd56;   // length field no longer fits
    localparam logic [5:0] LAST_POS  = 6'd63;

    localparam logic [31:0] SINE_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Message word used by a round: pass p, step q.
    function automatic logic [3:0] round_index(input logic [1:0] p, input logic [3:0] q);
        logic [3:0] idx;
        case (p)
            2'd0:    idx = q;
            2'd1:    idx = 4'(q * 4'd5 + 4'd1);
            2'd2:    idx = 4'(q * 4'd3 + 4'd5);
            default: idx = 4'(q * 4'd7);
        endcase
        return idx;
    endfunction

    // Left-rotate amount: pass p, low two bits of the step.
    function automatic logic [4:0] round_shift(input logic [1:0] p, input logic [1:0] q2);
        logic [4:0] s;
        case ({p, q2})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'hA: s = 5'd16;
            4'hB: s = 5'd23;
            4'hC: s = 5'd6;
            4'hD: s = 5'd10;
            4'hE: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/md5_core.sv =====
// ----------------------------------------------------------------------------
// MD5 compression core
// One shared round unit stepped 64 times per block, then a chain accumulate.
// ----------------------------------------------------------------------------
module md5_core import md5_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  md5_core_ctl_t    ctl,
    input  logic [31:0]      block_word,
    output logic [3:0]       block_index,
    output md5_core_status_t status,
    output md5_chain_t       chain
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ROUND = 2'd1;
    localparam logic [1:0] PH_ADD   = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  rnd_reg, rnd_next;
    md5_chain_t  chain_reg, chain_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;

    logic [1:0]  pass;
    logic [3:0]  step;
    logic [31:0] fv;
    logic [31:0] sum;
    logic [4:0]  shamt;
    logic [63:0] dbl;
    logic [31:0] new_b;

    assign pass        = rnd_reg[5:4];
    assign step        = rnd_reg[3:0];
    assign block_index = round_index(pass, step);
    assign shamt       = round_shift(pass, step[1:0]);

    always_comb
    begin
        case (pass)
            2'd0:    fv = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    fv = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    fv = b_reg ^ c_reg ^ d_reg;
            default: fv = c_reg ^ (b_reg | ~d_reg);
        endcase
    end

    assign sum   = a_reg + fv + SINE_TABLE[rnd_reg] + block_word;
    assign dbl   = {sum, sum} << shamt;
    assign new_b = b_reg + dbl[63:32];

    always_comb
    begin
        phase_next = phase_reg;
        rnd_next   = rnd_reg;
        chain_next = chain_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (ctl.reload)
                begin
                    chain_next = CHAIN_INIT;
                end
                if (ctl.start)
                begin
                    a_next     = chain_reg[0];
                    b_next     = chain_reg[1];
                    c_next     = chain_reg[2];
                    d_next     = chain_reg[3];
                    rnd_next   = '0;
                    phase_next = PH_ROUND;
                end
            end
            PH_ROUND:
            begin
                a_next   = d_reg;
                b_next   = new_b;
                c_next   = b_reg;
                d_next   = c_reg;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == LAST_POS)
                begin
                    phase_next = PH_ADD;
                end
            end
            PH_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                phase_next    = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rnd_reg   <= '0;
            chain_reg <= CHAIN_INIT;
        end
        else
        begin
            phase_reg <= phase_next;
            rnd_reg   <= rnd_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    assign status.busy = (phase_reg != PH_IDLE);
    assign status.done = (phase_reg == PH_ADD);
    assign chain       = chain_reg;

endmodule

// ===== hw/rtl/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest
// Streams a message in one byte per word and returns its 128-bit MD5 digest
// as four 32-bit chaining words (A, B, C, D) once the message is closed. A word
// carries a byte when has_byte is high and closes the message when
// end_of_message is high; both may be set together, the byte going in first,
// and an end mark alone after no bytes gives the digest of the empty message.
// Padding (0x80, zeros, 64-bit bit length) is added internally, and the chain
// restarts from the MD5 initial value for the next message. A byte that does
// not complete a 64-byte block leaves the input ready for the next word; the
// byte that does complete one starts the compression core, which runs one
// round per cycle for 64 rounds and then accumulates into the chain, and the
// block input is stalled throughout. Closing a message takes the pad step,
// the length step, one or two compressions (two when the pad byte lands in
// the last eight bytes of the block, leaving no room for the length) and a
// hand-over step for the digest; the input is stalled until it is done. The
// digest sits in an output register, so bytes of the next message are taken
// while it waits; only a second digest waits for the first to be collected,
// holding the hand-over step until then.
// ----------------------------------------------------------------------------
`include "md5_message_digest_defines.svh"

module md5_message_digest import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    // digest channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_a,
    output logic [31:0] digest_b,
    output logic [31:0] digest_c,
    output logic [31:0] digest_d
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0; // take words
    localparam logic [2:0] ST_COMP_BYTE = 3'd1; // block filled by a byte
    localparam logic [2:0] ST_PAD       = 3'd2; // place the 0x80 byte
    localparam logic [2:0] ST_COMP_PAD  = 3'd3; // overflow block after padding
    localparam logic [2:0] ST_LEN       = 3'd4; // place the bit length
    localparam logic [2:0] ST_COMP_LEN  = 3'd5; // final block
    localparam logic [2:0] ST_OUT       = 3'd6; // hand over the digest

    logic [2:0]  state_reg, state_next;
    logic [60:0] cnt_reg, cnt_next;
    logic        fin_reg, fin_next;
    logic [31:0] block_reg  [16];
    logic [31:0] block_next [16];
    logic        out_valid_reg, out_valid_next;
    md5_chain_t  digest_reg, digest_next;

    logic [5:0]        pos;
    logic [63:0]       bit_len;
    md5_core_ctl_t     core_ctl;
    md5_core_status_t  core_status;
    logic [3:0]        core_index;
    md5_chain_t        core_chain;

    // OR a byte into its lane of the block
    function automatic logic [31:0] merge_byte(input logic [31:0] word,
                                              input logic [1:0] lane,
                                              input logic [7:0] val);
        logic [31:0] shifted;
        shifted = {24'd0, val} << {lane, 3'b000};
        return word | shifted;
    endfunction

    assign pos     = cnt_reg[5:0];
    assign bit_len = {cnt_reg, 3'b000};

    md5_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (core_ctl),
        .block_word  (block_reg[core_index]),
        .block_index (core_index),
        .status      (core_status),
        .chain       (core_chain)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        block_next     = block_reg;
        digest_next    = digest_reg;
        out_valid_next = out_valid_reg;
        core_ctl       = '0;

        // drop the digest once it has been taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // empty the block as soon as its compression is done
        if (core_status.done)
        begin
            for (int i = 0; i < 16; i++)
            begin
                block_next[i] = '0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    fin_next = end_of_message;
                    if (has_byte)
                    begin
                        block_next[pos[5:2]] = merge_byte(block_reg[pos[5:2]], pos[1:0],
                                                          data_byte);
                        cnt_next = cnt_reg + 61'd1;
                        if (pos == LAST_POS)
                        begin
                            core_ctl.start = 1'b1;
                            state_next     = ST_COMP_BYTE;
                        end
                        else if (end_of_message)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_COMP_BYTE:
            begin
                if (core_status.done)
                begin
                    state_next = fin_reg ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD:
            begin
                block_next[pos[5:2]] = merge_byte(block_reg[pos[5:2]], pos[1:0], PAD_BYTE);
                if (pos >= PAD_LIMIT)
                begin
                    core_ctl.start = 1'b1;
                    state_next     = ST_COMP_PAD;
                end
                else
                begin
                    state_next = ST_LEN;
                end
            end
            ST_COMP_PAD:
            begin
                if (core_status.done)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                block_next[14] = bit_len[31:0];
                block_next[15] = bit_len[63:32];
                core_ctl.start = 1'b1;
                state_next     = ST_COMP_LEN;
            end
            ST_COMP_LEN:
            begin
                if (core_status.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    digest_next     = core_chain;
                    out_valid_next  = 1'b1;
                    core_ctl.reload = 1'b1;
                    cnt_next        = '0;
                    fin_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                block_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            block_reg     <= block_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digest_reg <= digest_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign digest_a  = digest_reg[0];
    assign digest_b  = digest_reg[1];
    assign digest_c  = digest_reg[2];
    assign digest_d  = digest_reg[3];

    `MD5_ASSERT_IMPLY(a_start_idle, core_ctl.start, !core_status.busy, "core started while busy")
    `MD5_ASSERT_IMPLY(a_reload_idle, core_ctl.reload, !core_status.busy, "chain reload mid-block")
    `MD5_ASSERT_IMPLY(a_ready_core, state_reg == ST_IDLE, !core_status.busy, "ready while core busy")
    `MD5_ASSERT_NEXT(a_last_done, core_status.done && state_reg == ST_COMP_LEN, state_reg == ST_OUT, "final block not followed by digest")
    `MD5_ASSERT_IMPLY(a_out_src, $rose(out_valid_reg), $past(state_reg == ST_OUT), "digest raised outside hand-over")

endmodule

// ===== sim/md5_message_digest_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MD5 message digest testbench
// Streams byte messages into the digest block under random sender gaps and
// receiver stalls. A behavioural MD5 predictor works out each expected digest,
// and a checker compares every digest word taken from the block, in order.
// ----------------------------------------------------------------------------
module md5_message_digest_tb;
    import md5_pkg::*;

    localparam int CLK_HALF_NS      = 6;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES      = 200;     // longer than one close with two compressions
    localparam int DRAIN_LIMIT      = 20000;
    localparam int RANDOM_WORDS     = 1200;

    // Left-rotate amounts, four per pass, indexed by pass * 4 + step % 4.
    localparam int unsigned ROT_AMOUNT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // Message lengths around the padding edges: the length field just fits,
    // just misses, and the block boundary itself, for one and two blocks.
    localparam int PAD_EDGE_LEN [12] = '{
        55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128, 129
    };

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte      = 8'h00;
    logic        has_byte       = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall      = 1'b1;
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;

    // Predictor state: chaining words, partly filled block and byte count.
    md5_chain_t  chain_st;
    logic [31:0] blk_st [16];
    logic [60:0] byte_cnt;

    md5_chain_t  pending_digests [$];

    int mismatches     = 0;
    int digests_seen   = 0;
    int digests_due    = 0;
    int bytes_sent     = 0;
    int idle_words     = 0;
    int ends_sent      = 0;
    int burst_left     = 0;
    int free_left      = 0;
    int stall_left     = 0;
    logic long_hold    = 1'b0;
    event long_hold_ev;

    md5_message_digest u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_a       (digest_a),
        .digest_b       (digest_b),
        .digest_c       (digest_c),
        .digest_d       (digest_d)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Return the chain to the initial value and empty the block.
    function automatic void md5_restart();
        int i;
        chain_st = CHAIN_INIT;
        for (i = 0; i < 16; i++)
        begin
            blk_st[i] = 32'h0;
        end
        byte_cnt = '0;
    endfunction

    // Run the 64 rounds over the current block, accumulate into the chain,
    // then clear the block for the next 64 bytes.
    function automatic void md5_compress_block();
        logic [31:0] a, b, c, d, f, sum;
        logic [63:0] twice;
        int r, g;
        a = chain_st[0];
        b = chain_st[1];
        c = chain_st[2];
        d = chain_st[3];
        for (r = 0; r < 64; r++)
        begin
            case (r / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = r % 16;
                end
                1:
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * r + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            sum   = a + f + SINE_TABLE[r] + blk_st[g];
            // the upper half of the doubled word shifted left is the rotation
            twice = {sum, sum} << ROT_AMOUNT[(r / 16) * 4 + r % 4];
            a = d;
            d = c;
            c = b;
            b = b + twice[63:32];
        end
        chain_st[0] = chain_st[0] + a;
        chain_st[1] = chain_st[1] + b;
        chain_st[2] = chain_st[2] + c;
        chain_st[3] = chain_st[3] + d;
        for (r = 0; r < 16; r++)
        begin
            blk_st[r] = 32'h0;
        end
    endfunction

    // Absorb one accepted word; on the end mark pad, finish and queue the digest.
    function automatic void md5_absorb_word(input logic [7:0] val, input logic hb,
                                            input logic eom);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        if (hb)
        begin
            pos = byte_cnt[5:0];
            blk_st[pos[5:2]][pos[1:0] * 8 +: 8] = val;
            byte_cnt = byte_cnt + 61'd1;
            if (pos == LAST_POS)
            begin
                md5_compress_block();
            end
        end
        if (eom)
        begin
            pos = byte_cnt[5:0];
            blk_st[pos[5:2]][pos[1:0] * 8 +: 8] = PAD_BYTE;
            if (pos >= PAD_LIMIT)
            begin
                md5_compress_block();
            end
            bit_len    = {byte_cnt, 3'b000};
            blk_st[14] = bit_len[31:0];
            blk_st[15] = bit_len[63:32];
            md5_compress_block();
            pending_digests.push_back(chain_st);
            digests_due++;
            md5_restart();
        end
    endfunction

    function automatic void log_mismatch(input string what);
        if (mismatches < 10)
        begin
            $display("[%0t] ERROR %s", $realtime, what);
        end
        mismatches++;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stall pattern, overridden by a long hold on request
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (long_hold)
        begin
            out_stall <= 1'b1;
        end
        else if (free_left > 0)
        begin
            out_stall <= 1'b0;
            free_left--;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            // now and then a long stretch with no stalls at all
            free_left  = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(0, 15);
            stall_left = $urandom_range(1, 10);
            out_stall <= 1'b0;
        end
    end

    // Count out the long hold here, apart from the sender.
    initial
    begin
        forever
        begin
            @(long_hold_ev);
            long_hold <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clk);
            long_hold <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Digest checker: compare each taken digest word with the oldest prediction
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin : digest_check
        md5_chain_t got;
        md5_chain_t want;
        int i;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {digest_d, digest_c, digest_b, digest_a};
            digests_seen++;
            if (pending_digests.size() == 0)
            begin
                log_mismatch($sformatf("digest with none outstanding: %h %h %h %h",
                                       got[0], got[1], got[2], got[3]));
            end
            else
            begin
                want = pending_digests.pop_front();
                for (i = 0; i < 4; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        log_mismatch($sformatf("digest %0d word %0d: expected %h, got %h",
                                               digests_seen, i, want[i], got[i]));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one word and hold it until it is taken. Bursts of random length
    // are separated by random gaps; a zero gap runs bursts back to back.
    task automatic offer_word(input logic [7:0] val, input logic hb, input logic eom);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid       <= 1'b1;
        data_byte      <= val;
        has_byte       <= hb;
        end_of_message <= eom;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        md5_absorb_word(val, hb, eom);
        if (hb)
        begin
            bytes_sent++;
        end
        if (eom)
        begin
            ends_sent++;
        end
        if (!hb && !eom)
        begin
            idle_words++;
        end
    endtask

    // Send a message of random bytes with the odd idle word mixed in. The end
    // mark rides on the last byte or follows in a word of its own.
    task automatic send_message(input int len, input bit join_end);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                offer_word(8'($urandom), 1'b0, 1'b0);
            end
            offer_word(8'($urandom), 1'b1, join_end && (i == len - 1));
        end
        if (!join_end || len == 0)
        begin
            offer_word(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // Pause the sender until every predicted digest has been collected.
    task automatic wait_for_digests();
        in_valid <= 1'b0;
        burst_left = 0;
        do
        begin
            @(posedge clk);
        end
        while (pending_digests.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty message, idle words, byte and end together, end on its own,
    // extreme byte values and the classic three-letter message.
    task automatic test_directed_cases();
        offer_word(8'hA5, 1'b0, 1'b1);          // empty message straight after reset
        offer_word(8'h5A, 1'b0, 1'b0);          // idle word outside any message
        offer_word(8'h00, 1'b1, 1'b1);          // single zero byte closing together
        offer_word(8'hFF, 1'b1, 1'b0);
        offer_word(8'h3C, 1'b0, 1'b0);          // idle word inside a message
        offer_word(8'hFF, 1'b1, 1'b0);
        offer_word(8'hC3, 1'b0, 1'b1);          // end mark on its own after bytes
        offer_word(8'h61, 1'b1, 1'b0);
        offer_word(8'h62, 1'b1, 1'b0);
        offer_word(8'h63, 1'b1, 1'b1);
        offer_word(8'h80, 1'b1, 1'b0);
        offer_word(8'h7F, 1'b1, 1'b1);
        offer_word(8'hFF, 1'b0, 1'b1);          // empty message again after a digest
        wait_for_digests();
    endtask

    // Half short messages, a quarter on the padding edges and the rest
    // spread over one to four blocks; now and then drain completely.
    task automatic test_random_messages();
        int sent_start;
        int len;
        int msgs;
        sent_start = bytes_sent + ends_sent;
        msgs = 0;
        while ((bytes_sent + ends_sent - sent_start) < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 3))
                0, 1:    len = $urandom_range(0, 16);
                2:       len = PAD_EDGE_LEN[$urandom_range(0, 11)];
                default: len = $urandom_range(17, 200);
            endcase
            send_message(len, 1'($urandom_range(0, 1)));
            msgs++;
            if (msgs % 8 == 0)
            begin
                wait_for_digests();
            end
        end
        wait_for_digests();
    endtask

    // Hold the receiver off for a long stretch while short messages keep
    // coming, so the output register fills and the block stalls its input.
    task automatic test_output_backpressure();
        int i;
        -> long_hold_ev;
        for (i = 0; i < 6; i++)
        begin
            send_message($urandom_range(0, 5), 1'($urandom_range(0, 1)));
        end
        wait_for_digests();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        int waited;
        md5_restart();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_output_backpressure();
        test_random_messages();
        test_output_backpressure();

        // drain whatever is still in flight, then watch for stray digests
        in_valid <= 1'b0;
        waited = 0;
        while (pending_digests.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        while (pending_digests.size() != 0)
        begin
            void'(pending_digests.pop_front());
            log_mismatch("predicted digest never delivered");
        end

        $display("Covered %0d messages, %0d bytes and %0d idle words under random gaps,",
                 ends_sent, bytes_sent, idle_words);
        $display("stalls and long hold-offs; %0d of %0d predicted digests compared.",
                 digests_seen, digests_due);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #10000000;
        $display("Run stopped at the time limit with %0d digests outstanding",
                 pending_digests.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
